// ----- rtl/core/ctb_pkg.sv -----
// Shared types, codes and saturating time helpers for the countdown timer bank.
package ctb_pkg;

   // Bank size and stored time width
   localparam int NUM_SLOTS  = 16;
   localparam int TIME_WIDTH = 32;
   localparam int POS_WIDTH  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   // Width used to compare a slot position against the 4-bit slot index
   localparam int CMP_WIDTH  = (POS_WIDTH > 4) ? POS_WIDTH : 4;
   // Headroom for one add or subtract of a 32-bit operand
   localparam int WIDE_WIDTH = ((TIME_WIDTH > 32) ? TIME_WIDTH : 32) + 1;

   typedef logic signed [TIME_WIDTH-1:0] time_type;
   typedef logic signed [WIDE_WIDTH-1:0] wide_type;
   typedef logic [POS_WIDTH-1:0]         pos_type;

   localparam wide_type TIME_MAX_W = wide_type'({1'b0, {(TIME_WIDTH-1){1'b1}}});
   localparam wide_type TIME_MIN_W = -TIME_MAX_W - wide_type'(1);

   typedef enum logic [3:0] {
      OP_CREATE  = 4'd0,
      OP_DELETE  = 4'd1,
      OP_START   = 4'd2,
      OP_STOP    = 4'd3,
      OP_ADD     = 4'd4,
      OP_SET     = 4'd5,
      OP_QUERY   = 4'd6,
      OP_TICK    = 4'd7,
      OP_PAUSE   = 4'd8,
      OP_UNPAUSE = 4'd9
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_NO_FREE    = 2'd1,
      ST_NOT_IN_USE = 2'd2
   } status_type;

   // Per-slot payload; the in-use bit is kept apart since only it is reset
   typedef struct packed {
      time_type time_left;
      logic     running;
      logic     paused;
      logic     ended;
   } slot_data_type;

   typedef struct packed {
      logic          used;
      slot_data_type data;
   } slot_rec_type;

   // Command seen by the update stage at the head of the ring
   typedef struct packed {
      opcode_type         op;
      logic signed [31:0] amount;
      logic               target;
      logic               alloc_open;
   } slot_cmd_type;

   // What the update stage reports about the slot it just handled
   typedef struct packed {
      logic used_before;
      logic allocated;
   } slot_flags_type;

   function automatic logic is_slot_op(input opcode_type op);
      case (op) inside
         OP_DELETE, OP_START, OP_STOP, OP_ADD, OP_SET, OP_QUERY: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

   function automatic wide_type widen_time(input time_type t);
      return wide_type'(t);
   endfunction

   function automatic wide_type widen_in(input logic signed [31:0] v);
      return wide_type'(v);
   endfunction

   // Clamp to the signed TIME_WIDTH range
   function automatic time_type sat_time(input wide_type x);
      if (x > TIME_MAX_W) begin
         return time_type'(TIME_MAX_W);
      end
      if (x < TIME_MIN_W) begin
         return time_type'(TIME_MIN_W);
      end
      return time_type'(x);
   endfunction

   // Low 32 bits of a stored time, sign-extended if the store is narrower
   function automatic logic [31:0] to_out(input time_type t);
      return 32'(t);
   endfunction

endpackage

// ----- rtl/core/countdown_timer_bank.sv -----
// Top level of the countdown timer bank: command channel, slot ring and result channel.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  opcode, slot_index, time_value
//   rsp      out  rsp_tvalid/rsp_tready  status, result_index, time_left, has_ended
//
// Each command is accepted, then the ring shifts until every slot has passed the update
// stage once, and the result is loaded when the result register is free.
// The ring is back in slot order after each command.
// Reset clears every in-use bit; the slot payloads are written by create.
// A new command is taken while the previous result still waits on rsp_tready;
// a finished command holds until the result register is free.
module countdown_timer_bank import ctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // opcode[3:0], slot_index[7:4], time_value[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // status[1:0], result_index[5:2], time_left[37:6],
                                    // has_ended[38], zero[39]
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_HOLD = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   pos_type            pos_ff;
   logic               found_ff;
   opcode_type         op_ff;
   logic [3:0]         idx_ff;
   logic signed [31:0] amount_ff;

   status_type         res_status_ff;
   logic [3:0]         res_index_ff;
   logic [31:0]        res_time_ff;
   logic               res_ended_ff;

   logic               rsp_valid_ff;
   logic [39:0]        rsp_data_ff;

   logic               req_fire;
   logic               last_pos;
   logic               rsp_load;
   logic               shift_en;

   slot_rec_type       cell_rec [NUM_SLOTS];
   slot_rec_type       link     [NUM_SLOTS];
   slot_rec_type       head_out;
   slot_cmd_type       cmd;
   slot_flags_type     flags;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign last_pos   = (pos_ff == pos_type'(NUM_SLOTS - 1));
   assign shift_en   = (state_ff == S_SCAN);
   assign rsp_load   = (state_ff == S_HOLD) && (!rsp_valid_ff || rsp_tready);

   // Command at the head of the ring
   assign cmd.op         = op_ff;
   assign cmd.amount     = amount_ff;
   assign cmd.target     = (CMP_WIDTH'(pos_ff) == CMP_WIDTH'(idx_ff));
   assign cmd.alloc_open = !found_ff;

   ctb_slot_op u_slot_op (
      .cmd     (cmd),
      .rec_in  (cell_rec[0]),
      .rec_out (head_out),
      .flags   (flags)
   );

   // Ring of slot cells: each takes its upper neighbor, the top takes the update
   for (genvar gi = 0; gi < NUM_SLOTS; gi++) begin : g_ring
      if (gi == NUM_SLOTS - 1) begin : g_top
         assign link[gi] = head_out;
      end else begin : g_mid
         assign link[gi] = cell_rec[gi+1];
      end
      ctb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .rec_in   (link[gi]),
         .rec_out  (cell_rec[gi])
      );
   end

   // Sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_fire) state_in = S_SCAN;
         S_SCAN: if (last_pos) state_in = S_HOLD;
         S_HOLD: if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_fire) begin
            pos_ff   <= '0;
            found_ff <= 1'b0;
         end else if (shift_en) begin
            pos_ff <= last_pos ? pos_type'(0) : pos_ff + pos_type'(1);
            if (flags.allocated) begin
               found_ff <= 1'b1;
            end
         end
      end
   end

   // Command capture and result gathering during the scan
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff        <= opcode_type'(req_tdata[3:0]);
         idx_ff       <= req_tdata[7:4];
         amount_ff    <= req_tdata[39:8];
         res_time_ff  <= '0;
         res_ended_ff <= 1'b0;
         if (opcode_type'(req_tdata[3:0]) == OP_CREATE) begin
            res_status_ff <= ST_NO_FREE;
            res_index_ff  <= '0;
         end else begin
            res_status_ff <= is_slot_op(opcode_type'(req_tdata[3:0])) ?
                             ST_NOT_IN_USE : ST_OK;
            res_index_ff  <= req_tdata[7:4];
         end
      end else if (shift_en) begin
         if (op_ff == OP_CREATE) begin
            if (flags.allocated) begin
               res_status_ff <= ST_OK;
               res_index_ff  <= 4'(pos_ff);
               res_time_ff   <= to_out(head_out.data.time_left);
               res_ended_ff  <= head_out.data.ended;
            end
         end else if (cmd.target) begin
            if (is_slot_op(op_ff)) begin
               res_status_ff <= flags.used_before ? ST_OK : ST_NOT_IN_USE;
            end
            res_time_ff  <= head_out.used ? to_out(head_out.data.time_left) : '0;
            res_ended_ff <= head_out.used && head_out.data.ended;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= {1'b0, res_ended_ff, res_time_ff, res_index_ff, res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef NO_ASSERTIONS
   // an accepted command always starts a scan
   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_SCAN)
      else $error("accepted command did not start a scan");

   // the ring is in slot order whenever no scan runs
   a_ring_aligned: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_SCAN |-> pos_ff == '0)
      else $error("ring position not aligned outside a scan");

   // the scan position steps by one each cycle
   a_pos_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && !last_pos |=> pos_ff == $past(pos_ff) + pos_type'(1))
      else $error("ring position skipped");

   // a result is loaded only into a free or draining output register
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready && state_ff == S_HOLD |=> state_ff == S_HOLD)
      else $error("result register overwritten");
`endif

endmodule

// ----- rtl/core/ctb_cell.sv -----
// One ring cell: holds a timer slot and takes its neighbor's slot on each shift.
module ctb_cell import ctb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         shift_en,
   input  slot_rec_type rec_in,
   output slot_rec_type rec_out
);

   logic          used_ff;
   slot_data_type data_ff;

   // In-use bit: cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (shift_en) begin
         used_ff <= rec_in.used;
      end
   end

   // Slot payload: only meaningful once the slot is created
   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= rec_in.data;
      end
   end

   assign rec_out.used = used_ff;
   assign rec_out.data = data_ff;

endmodule

// ----- rtl/core/ctb_slot_op.sv -----
// Update stage at the head of the ring: applies the current command to one slot.
module ctb_slot_op import ctb_pkg::*; (
   input  slot_cmd_type   cmd,
   input  slot_rec_type   rec_in,
   output slot_rec_type   rec_out,
   output slot_flags_type flags
);

   always_comb begin
      rec_out           = rec_in;
      flags.used_before = rec_in.used;
      flags.allocated   = 1'b0;
      unique case (cmd.op)
         OP_CREATE: begin
            // first free slot in index order wins
            if (!rec_in.used && cmd.alloc_open) begin
               rec_out.used           = 1'b1;
               rec_out.data.time_left = sat_time(widen_in(cmd.amount));
               rec_out.data.running   = 1'b1;
               rec_out.data.paused    = 1'b0;
               rec_out.data.ended     = 1'b0;
               flags.allocated        = 1'b1;
            end
         end
         OP_DELETE: begin
            if (cmd.target && rec_in.used) begin
               rec_out.used = 1'b0;
            end
         end
         OP_START: begin
            if (cmd.target && rec_in.used) begin
               rec_out.data.running = 1'b1;
            end
         end
         OP_STOP: begin
            if (cmd.target && rec_in.used) begin
               rec_out.data.running = 1'b0;
            end
         end
         OP_ADD: begin
            if (cmd.target && rec_in.used) begin
               rec_out.data.time_left =
                  sat_time(widen_time(rec_in.data.time_left) + widen_in(cmd.amount));
            end
         end
         OP_SET: begin
            if (cmd.target && rec_in.used) begin
               rec_out.data.time_left = sat_time(widen_in(cmd.amount));
               rec_out.data.ended     = 1'b0;
            end
         end
         OP_TICK: begin
            if (rec_in.used) begin
               if (rec_in.data.running && !rec_in.data.paused) begin
                  rec_out.data.time_left =
                     sat_time(widen_time(rec_in.data.time_left) - widen_in(cmd.amount));
               end
               // sticky: set once the time reaches zero or below
               if (rec_out.data.time_left <= time_type'(0)) begin
                  rec_out.data.ended = 1'b1;
               end
            end
         end
         OP_PAUSE: begin
            if (rec_in.used) begin
               rec_out.data.paused = 1'b1;
            end
         end
         OP_UNPAUSE: begin
            if (rec_in.used) begin
               rec_out.data.paused = 1'b0;
            end
         end
         default: begin
            // query and undefined codes leave the slot alone
         end
      endcase
   end

endmodule

// ----- verif/countdown_timer_bank_tb.sv -----
// Testbench for the countdown timer bank: directed table, random commands and a scoreboard.
`timescale 1ns / 1ps

module countdown_timer_bank_tb;
   import ctb_pkg::*;

   localparam int          RANDOM_ITEMS  = 750;
   localparam int          SEGMENT_LEN   = 50;
   localparam int          DIRECTED_ROWS = 25;
   localparam int          DRAIN_CYCLES  = 40;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam logic [31:0] AMOUNT_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] AMOUNT_MIN    = 32'h8000_0000;
   localparam logic [31:0] ONE_SECOND    = 32'h0001_0000;
   localparam logic [3:0]  OP_UNDEF_LO   = 4'd10;
   localparam logic [3:0]  OP_UNDEF_HI   = 4'd15;
   localparam longint      TIME_HI       = (longint'(1) <<< (TIME_WIDTH - 1)) - 1;
   localparam longint      TIME_LO       = -TIME_HI - 1;

   typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic [31:0] time_left;
      logic        ended;
   } timer_result_type;

   // fixed rows carry a hand-written result; the rest go through the predictor
   typedef struct packed {
      logic [3:0]       op;
      logic [3:0]       slot;
      logic [31:0]      amount;
      logic             fixed;
      timer_result_type want;
   } directed_row_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;

   // Predictor copy of the bank
   logic   slot_used    [NUM_SLOTS];
   longint slot_time    [NUM_SLOTS];
   logic   slot_running [NUM_SLOTS];
   logic   slot_paused  [NUM_SLOTS];
   logic   slot_ended   [NUM_SLOTS];

   timer_result_type pending_results [$];
   int               error_count  = 0;
   int               cycle_count  = 0;
   int               stall_left   = 0;
   logic             send_gaps_on = 1'b1;
   logic             recv_gaps_on = 1'b1;

   countdown_timer_bank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      for (int k = 0; k < NUM_SLOTS; k++) begin
         slot_used[k]    = 1'b0;
         slot_time[k]    = 0;
         slot_running[k] = 1'b0;
         slot_paused[k]  = 1'b0;
         slot_ended[k]   = 1'b0;
      end
   end

   function automatic longint clamp_time(input longint x);
      if (x > TIME_HI) begin
         return TIME_HI;
      end
      if (x < TIME_LO) begin
         return TIME_LO;
      end
      return x;
   endfunction

   // Applies one command to the predictor state and returns the beat it should produce
   function automatic timer_result_type apply_timer_command(input logic [3:0] op,
                                                            input logic [3:0] slot,
                                                            input logic [31:0] amount);
      timer_result_type res;
      longint           delta;
      int               addr;
      logic             hit;
      delta      = longint'($signed(amount));
      addr       = slot;
      hit        = slot_used[slot];
      res.status = ST_OK;
      res.slot   = slot;
      case (op)
         OP_CREATE: begin
            res.status = ST_NO_FREE;
            res.slot   = '0;
            hit        = 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (!slot_used[k] && !hit) begin
                  hit             = 1'b1;
                  slot_used[k]    = 1'b1;
                  slot_time[k]    = clamp_time(delta);
                  slot_running[k] = 1'b1;
                  slot_paused[k]  = 1'b0;
                  slot_ended[k]   = 1'b0;
                  res.slot        = 4'(k);
                  res.status      = ST_OK;
                  addr            = k;
               end
            end
         end
         OP_DELETE, OP_START, OP_STOP, OP_ADD, OP_SET, OP_QUERY: begin
            if (!hit) begin
               res.status = ST_NOT_IN_USE;
            end else begin
               case (op)
                  OP_DELETE: begin
                     slot_used[addr] = 1'b0;
                     hit             = 1'b0;
                  end
                  OP_START: slot_running[addr] = 1'b1;
                  OP_STOP:  slot_running[addr] = 1'b0;
                  OP_ADD:   slot_time[addr] = clamp_time(slot_time[addr] + delta);
                  OP_SET: begin
                     slot_time[addr]  = clamp_time(delta);
                     slot_ended[addr] = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         OP_TICK: begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (slot_used[k]) begin
                  if (slot_running[k] && !slot_paused[k]) begin
                     slot_time[k] = clamp_time(slot_time[k] - delta);
                  end
                  if (slot_time[k] <= 0) begin
                     slot_ended[k] = 1'b1;
                  end
               end
            end
         end
         OP_PAUSE, OP_UNPAUSE: begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
               if (slot_used[k]) begin
                  slot_paused[k] = (op == OP_PAUSE);
               end
            end
         end
         default: ;
      endcase
      res.time_left = hit ? slot_time[addr][31:0] : 32'h0;
      res.ended     = hit && slot_ended[addr];
      return res;
   endfunction

   function automatic directed_row_type directed_row(input int i);
      case (i)
         0:  return '{OP_DELETE, 4'd15, 32'h0, 1'b1, '{ST_NOT_IN_USE, 4'd15, 32'h0, 1'b0}};
         1:  return '{OP_TICK, 4'd3, ONE_SECOND, 1'b1, '{ST_OK, 4'd3, 32'h0, 1'b0}};
         2:  return '{OP_CREATE, 4'd9, AMOUNT_MAX, 1'b1, '{ST_OK, 4'd0, AMOUNT_MAX, 1'b0}};
         3:  return '{OP_CREATE, 4'd0, AMOUNT_MIN, 1'b1, '{ST_OK, 4'd1, AMOUNT_MIN, 1'b0}};
         4:  return '{OP_CREATE, 4'd0, 32'h0, 1'b1, '{ST_OK, 4'd2, 32'h0, 1'b0}};
         // saturation at both ends
         5:  return '{OP_ADD, 4'd0, 32'h1, 1'b1, '{ST_OK, 4'd0, AMOUNT_MAX, 1'b0}};
         6:  return '{OP_ADD, 4'd1, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 4'd1, AMOUNT_MIN, 1'b0}};
         7:  return '{OP_TICK, 4'd2, AMOUNT_MIN, 1'b0, '0};
         8:  return '{OP_QUERY, 4'd1, 32'h0, 1'b0, '0};
         9:  return '{OP_TICK, 4'd0, AMOUNT_MAX, 1'b0, '0};
         // paused and stopped slots hold their time through a tick
         10: return '{OP_SET, 4'd2, 32'h0004_0000, 1'b0, '0};
         11: return '{OP_PAUSE, 4'd2, 32'h0, 1'b0, '0};
         12: return '{OP_TICK, 4'd2, ONE_SECOND, 1'b0, '0};
         13: return '{OP_UNPAUSE, 4'd2, 32'h0, 1'b0, '0};
         14: return '{OP_STOP, 4'd2, 32'h0, 1'b0, '0};
         15: return '{OP_TICK, 4'd2, ONE_SECOND, 1'b0, '0};
         16: return '{OP_START, 4'd2, 32'h0, 1'b0, '0};
         17: return '{OP_SET, 4'd1, 32'hFFFF_0000, 1'b0, '0};
         18: return '{OP_DELETE, 4'd1, 32'h0, 1'b1, '{ST_OK, 4'd1, 32'h0, 1'b0}};
         19: return '{OP_CREATE, 4'd7, 32'h0003_0000, 1'b1, '{ST_OK, 4'd1, 32'h0003_0000, 1'b0}};
         20: return '{OP_UNDEF_HI, 4'd2, AMOUNT_MAX, 1'b0, '0};
         // commands on free slots
         21: return '{OP_QUERY, 4'd7, 32'h0, 1'b1, '{ST_NOT_IN_USE, 4'd7, 32'h0, 1'b0}};
         22: return '{OP_START, 4'd5, 32'h0, 1'b1, '{ST_NOT_IN_USE, 4'd5, 32'h0, 1'b0}};
         23: return '{OP_ADD, 4'd8, ONE_SECOND, 1'b1, '{ST_NOT_IN_USE, 4'd8, 32'h0, 1'b0}};
         default: return '{OP_SET, 4'd9, ONE_SECOND, 1'b1, '{ST_NOT_IN_USE, 4'd9, 32'h0, 1'b0}};
      endcase
   endfunction

   // Mostly short waits, a few long ones
   function automatic int pick_wait(input logic enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 60) begin
         return 0;
      end
      if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [3:0] pick_opcode(input mix_type mix);
      int r;
      int create_w;
      int delete_w;
      create_w = (mix == MIX_FILL) ? 45 : (mix == MIX_DRAIN) ? 5 : 15;
      delete_w = (mix == MIX_DRAIN) ? 35 : (mix == MIX_FILL) ? 3 : 10;
      r = $urandom_range(0, 99);
      if (r < create_w) begin
         return OP_CREATE;
      end
      if (r < create_w + delete_w) begin
         return OP_DELETE;
      end
      r = $urandom_range(0, 99);
      if (r < 10) return OP_START;
      if (r < 20) return OP_STOP;
      if (r < 35) return OP_ADD;
      if (r < 47) return OP_SET;
      if (r < 62) return OP_QUERY;
      if (r < 86) return OP_TICK;
      if (r < 92) return OP_PAUSE;
      if (r < 98) return OP_UNPAUSE;
      return 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
   endfunction

   // Usually a live slot, so commands get past the in-use check
   function automatic logic [3:0] pick_slot();
      int live [$];
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (slot_used[k]) begin
            live.push_back(k);
         end
      end
      if (live.size() != 0 && $urandom_range(0, 3) != 0) begin
         return 4'(live[$urandom_range(0, live.size() - 1)]);
      end
      return 4'($urandom_range(0, 15));
   endfunction

   // Small times so timers actually run out; extremes and full-range now and then
   function automatic logic [31:0] pick_amount(input logic [3:0] op);
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return AMOUNT_MAX;
      if (r == 1) return AMOUNT_MIN;
      if (r < 4)  return $urandom;
      case (op)
         OP_TICK: return $urandom_range(0, 32'h0002_0000);
         OP_ADD:  return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom_range(0, 32'h000A_0000);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("mismatch %s: got %0h, want %0h (cycle %0d)", what, got, want, cycle_count);
   endtask

   // Drive one command beat and queue its expected result once it is taken
   task automatic send_command(input logic [3:0] op, input logic [3:0] slot,
                               input logic [31:0] amount, input logic fixed,
                               input timer_result_type want);
      int               gap;
      timer_result_type predicted;
      gap = pick_wait(send_gaps_on);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {amount, slot, op};
      do @(posedge clock); while (!req_tready);
      predicted = apply_timer_command(op, slot, amount);
      pending_results.push_back(fixed ? want : predicted);
   endtask

   // Result side stalls
   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 99) < 15) begin
            stall_left <= pick_wait(recv_gaps_on);
         end
      end
   end

   // Scoreboard
   always @(posedge clock) begin
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result beat with none pending", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] != want.status) begin
               report_mismatch("status", 32'(rsp_tdata[1:0]), 32'(want.status));
            end
            if (rsp_tdata[5:2] != want.slot) begin
               report_mismatch("result_index", 32'(rsp_tdata[5:2]), 32'(want.slot));
            end
            if (rsp_tdata[37:6] != want.time_left) begin
               report_mismatch("time_left", rsp_tdata[37:6], want.time_left);
            end
            if (rsp_tdata[38] != want.ended) begin
               report_mismatch("has_ended", 32'(rsp_tdata[38]), 32'(want.ended));
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      directed_row_type row;
      mix_type          mix;
      logic [3:0]       op;
      mix = MIX_CHURN;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = directed_row(i);
         send_command(row.op, row.slot, row.amount, row.fixed, row.want);
      end

      // Random commands in segments with their own mix and idling
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            mix          = mix_type'($urandom_range(0, 2));
            send_gaps_on = ($urandom_range(0, 3) != 0);
            recv_gaps_on = ($urandom_range(0, 3) != 0);
         end
         // hold off until the bank has answered everything
         if (n == RANDOM_ITEMS / 2) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(posedge clock);
         end
         op = pick_opcode(mix);
         send_command(op, pick_slot(), pick_amount(op), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
